>>> rtl/crc8fc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the CRC-8 frame checker.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package crc8fc_pkg;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [CsrAddrWidth-1:0] CSR_ADDR_POLY = 3'd0;

   localparam logic [7:0] POLY_RESET      = 8'h1D;
   localparam logic [7:0] HEADER_XOR      = 8'hFF;
   localparam logic [7:0] COUNT_MAX       = 8'hFF;
   localparam logic [7:0] MIN_FRAME_BYTES = 8'd5;

   localparam logic [2:0] STATUS_OK     = 3'd0;
   localparam logic [2:0] STATUS_SHORT  = 3'd1;
   localparam logic [2:0] STATUS_HEADER = 3'd2;
   localparam logic [2:0] STATUS_LENGTH = 3'd3;
   localparam logic [2:0] STATUS_CRC    = 3'd4;

   typedef struct packed {
      logic       frame_ok;
      logic [2:0] frame_status;
   } verdict_type;

   function automatic logic [7:0] crc8_absorb(input logic [7:0] crc, input logic [7:0] data,
                                              input logic [7:0] poly);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ poly;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

>>> rtl/crc8fc_csr.sv
// APB-style register port holding the CRC-8 generator polynomial.
// Depends on crc8fc_pkg.
`timescale 1ns / 1ps

module crc8fc_csr
   import crc8fc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output logic [7:0]              crc_polynomial
);

   logic [7:0] poly_ff;
   logic [7:0] poly_in;
   logic       wr_poly;

   assign csr_pready = 1'b1;
   assign wr_poly = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                    (csr_paddr == CSR_ADDR_POLY);

   always_comb begin
      poly_in = poly_ff;
      if (wr_poly) begin
         poly_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
      end else begin
         poly_ff <= poly_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_POLY) begin
         csr_prdata = {{(CsrDataWidth-8){1'b0}}, poly_ff};
      end
   end

   assign crc_polynomial = poly_ff;

endmodule

>>> rtl/crc8fc_frame.sv
// Per-frame state (running CRC, byte count, header, length field) and verdict logic.
// Depends on crc8fc_pkg.
`timescale 1ns / 1ps

module crc8fc_frame
   import crc8fc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  rx_byte,
   input  logic        end_of_frame,
   input  logic [7:0]  crc_polynomial,
   output verdict_type verdict
);

   logic [7:0] crc_ff,   crc_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] first_ff, first_in;
   logic       hdr_ff,   hdr_in;
   logic [7:0] len_ff,   len_in;
   logic [7:0] count_next;
   logic       hdr_now;
   logic [7:0] len_now;

   assign count_next = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 8'd1;
   assign hdr_now    = (count_ff == 8'd1) ? ((first_ff ^ rx_byte) == HEADER_XOR) : hdr_ff;
   assign len_now    = (count_ff == 8'd2) ? rx_byte : len_ff;

   always_comb begin
      verdict.frame_status = STATUS_OK;
      if (count_next < MIN_FRAME_BYTES) begin
         verdict.frame_status = STATUS_SHORT;
      end else if (!hdr_now) begin
         verdict.frame_status = STATUS_HEADER;
      end else if (len_now != count_next) begin
         verdict.frame_status = STATUS_LENGTH;
      end else if (rx_byte != crc_ff) begin
         verdict.frame_status = STATUS_CRC;
      end
      verdict.frame_ok = (verdict.frame_status == STATUS_OK);
   end

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      first_in = first_ff;
      hdr_in   = hdr_ff;
      len_in   = len_ff;
      if (step) begin
         if (end_of_frame) begin
            crc_in   = '0;
            count_in = '0;
            first_in = '0;
            hdr_in   = 1'b0;
            len_in   = '0;
         end else begin
            crc_in   = crc8_absorb(crc_ff, rx_byte, crc_polynomial);
            count_in = count_next;
            hdr_in   = hdr_now;
            len_in   = len_now;
            if (count_ff == 8'd0) begin
               first_in = rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         count_ff <= '0;
         first_ff <= '0;
         hdr_ff   <= 1'b0;
         len_ff   <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         first_ff <= first_in;
         hdr_ff   <= hdr_in;
         len_ff   <= len_in;
      end
   end

endmodule

>>> rtl/crc8_frame_checker_unit.sv
// Top level of the CRC-8 frame checker: input register, frame logic, result register.
// Depends on crc8fc_pkg, crc8fc_csr and crc8fc_frame.
//
//   channel  direction  tdata / tuser                         tlast
//   req_     in         tdata[7:0] rx_byte                    end_of_frame
//   rsp_     out        tdata[0] frame_ok, [3:1] frame_status  -
//   csr_     in/out     register 0 at 0x0: crc_polynomial     -
//
// One byte per cycle unless a marked byte stalls; its verdict is offered from the result register.
// The input register feeds the CRC update and verdict logic; the result register holds
// a verdict until rsp_tready. Bytes keep flowing while a verdict waits; only a marked
// byte stalls behind an untaken verdict. Reset is synchronous and clears all frame state.
`timescale 1ns / 1ps

module crc8_frame_checker_unit
   import crc8fc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] rx_byte
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // [0] frame_ok, [3:1] frame_status, [7:4] zero
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_last_ff, in_last_in;
   logic        out_vld_ff, out_vld_in;
   verdict_type out_ff, out_in;
   verdict_type verdict;
   logic [7:0]  poly;
   logic        out_free;
   logic        step;

   crc8fc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .crc_polynomial (poly)
   );

   crc8fc_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .rx_byte        (in_byte_ff),
      .end_of_frame   (in_last_ff),
      .crc_polynomial (poly),
      .verdict        (verdict)
   );

   assign out_free   = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && (!in_last_ff || out_free);
   assign req_tready = !in_vld_ff || step;

   always_comb begin
      in_vld_in  = in_vld_ff && !step;
      in_byte_in = in_byte_ff;
      in_last_in = in_last_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_tdata;
         in_last_in = req_tlast;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_tready;
      out_in     = out_ff;
      if (step && in_last_ff) begin
         out_vld_in = 1'b1;
         out_in     = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'b0000, out_ff.frame_status, out_ff.frame_ok};

endmodule

>>> verif/tb_crc8_frame_checker_unit.sv
// Self-checking testbench for crc8_frame_checker_unit: streams frames through the byte
// port, predicts each verdict in a scoreboard class and checks it on the result port.
// Depends on crc8fc_pkg and the RTL of crc8_frame_checker_unit only.
`timescale 1ns / 1ps

class frame_verdict_board;
   logic [7:0] polynomial;
   logic [7:0] crc_so_far;
   logic [7:0] bytes_seen;
   logic [7:0] header_byte0;
   logic       header_pass;
   logic [7:0] length_byte;
   crc8fc_pkg::verdict_type pending[$];
   int unsigned mismatches;
   int unsigned verdicts_checked;

   function new();
      polynomial       = crc8fc_pkg::POLY_RESET;
      mismatches       = 0;
      verdicts_checked = 0;
      restart_frame();
   endfunction

   function void restart_frame();
      crc_so_far   = 8'h00;
      bytes_seen   = 8'h00;
      header_byte0 = 8'h00;
      header_pass  = 1'b0;
      length_byte  = 8'h00;
   endfunction

   // bit-serial form: feed one data bit per shift, MSB first
   static function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data,
                                        input logic [7:0] poly);
      logic [7:0] acc;
      logic       feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[7] ^ data[i];
         acc      = {acc[6:0], 1'b0} ^ (feedback ? poly : 8'h00);
      end
      return acc;
   endfunction

   function void note_byte(input logic [7:0] data, input logic last);
      logic [7:0] position;
      logic [7:0] count;
      logic [2:0] status;
      crc8fc_pkg::verdict_type verdict;
      position = bytes_seen;
      count    = (bytes_seen == crc8fc_pkg::COUNT_MAX) ? bytes_seen : bytes_seen + 8'd1;
      if (position == 8'd0) begin
         header_byte0 = data;
      end else if (position == 8'd1) begin
         header_pass = ((header_byte0 ^ data) == crc8fc_pkg::HEADER_XOR);
      end else if (position == 8'd2) begin
         length_byte = data;
      end
      if (!last) begin
         crc_so_far = crc_step(crc_so_far, data, polynomial);
         bytes_seen = count;
         return;
      end
      if (count < crc8fc_pkg::MIN_FRAME_BYTES) begin
         status = crc8fc_pkg::STATUS_SHORT;
      end else if (!header_pass) begin
         status = crc8fc_pkg::STATUS_HEADER;
      end else if (length_byte != count) begin
         status = crc8fc_pkg::STATUS_LENGTH;
      end else if (data != crc_so_far) begin
         status = crc8fc_pkg::STATUS_CRC;
      end else begin
         status = crc8fc_pkg::STATUS_OK;
      end
      verdict.frame_ok     = (status == crc8fc_pkg::STATUS_OK);
      verdict.frame_status = status;
      pending = {pending, verdict};
      restart_frame();
   endfunction

   function void check_verdict(input logic [7:0] tdata);
      crc8fc_pkg::verdict_type want;
      if (pending.size() == 0) begin
         $display("%0t: verdict %h arrived with none expected", $time, tdata);
         mismatches++;
         return;
      end
      want = pending.pop_front();
      verdicts_checked++;
      if (tdata[0] !== want.frame_ok) begin
         $display("%0t: frame_ok expected %0d got %0d", $time, want.frame_ok, tdata[0]);
         mismatches++;
      end
      if (tdata[3:1] !== want.frame_status) begin
         $display("%0t: frame_status expected %0d got %0d", $time, want.frame_status,
                  tdata[3:1]);
         mismatches++;
      end
      if (tdata[7:4] !== 4'h0) begin
         $display("%0t: tdata padding expected 0 got %h", $time, tdata[7:4]);
         mismatches++;
      end
   endfunction
endclass

module tb_crc8_frame_checker_unit;
   import crc8fc_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   localparam int unsigned LIMIT_CYCLES = 1000000;
   localparam int unsigned RANDOM_BYTES = 1500;
   localparam int unsigned IDLE_TAIL    = 6;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned PHASES       = 7;
   localparam logic [CsrAddrWidth-1:0] UNMAPPED_ADDR = 3'd4;

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata   = 8'h00;  // [7:0] rx_byte
   logic                    req_tlast   = 1'b0;   // end_of_frame
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [7:0]              rsp_tdata;            // [0] frame_ok, [3:1] frame_status
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   frame_verdict_board board = new();

   int unsigned pause_before      = 0;
   int unsigned bytes_sent        = 0;
   int unsigned frames_sent       = 0;
   int unsigned poly_settings     = 0;
   int unsigned long_holds        = 0;
   bit          steady            = 1'b0;
   bit          long_hold_request = 1'b0;

   crc8_frame_checker_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("timeout after %0d cycles, %0d verdicts outstanding", LIMIT_CYCLES,
               board.pending.size());
      $display("tb_crc8_frame_checker_unit: FAIL");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] crc_of(input byte_queue_type data, input logic [7:0] poly,
                                         input logic [7:0] seed);
      logic [7:0] acc;
      acc = seed;
      foreach (data[i]) begin
         acc = board.crc_step(acc, data[i], poly);
      end
      return acc;
   endfunction

   function automatic byte_queue_type random_frame();
      byte_queue_type f;
      int unsigned    n;
      int unsigned    kind;
      int unsigned    fault;
      logic           bad_header;
      logic           bad_length;
      logic           bad_crc;
      logic [7:0]     b0;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         n = $urandom_range(1, 4);
      end else if (kind < 16) begin
         n = $urandom_range(1, 12);
      end else if (kind < 19) begin
         n = $urandom_range(0, 1) ? $urandom_range(253, 258) : $urandom_range(259, 300);
      end else begin
         n = $urandom_range(5, 20);
      end
      if (kind < 16) begin
         repeat (n) f = {f, 8'($urandom())};
         return f;
      end
      fault      = $urandom_range(0, 99);
      bad_header = (fault >= 50 && fault < 62) || (fault >= 86 && $urandom_range(0, 1));
      bad_length = (fault >= 62 && fault < 74) || (fault >= 86 && $urandom_range(0, 1));
      bad_crc    = (fault >= 74 && fault < 86) || (fault >= 86 && $urandom_range(0, 1));
      b0 = 8'($urandom());
      f = {f, b0};
      f = {f, ~b0 ^ (bad_header ? 8'(1 << $urandom_range(0, 7)) : 8'h00)};
      f = {f, (n >= 255 ? COUNT_MAX : 8'(n)) ^
              (bad_length ? 8'(1 << $urandom_range(0, 7)) : 8'h00)};
      repeat (n - 4) f = {f, 8'($urandom())};
      f = {f, crc_of(f, board.polynomial, 8'h00) ^
              (bad_crc ? 8'(1 << $urandom_range(0, 7)) : 8'h00)};
      return f;
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic last);
      if (pause_before > 0) begin
         repeat (pause_before) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_byte(data, last);
      bytes_sent++;
      pause_before = pick_gap();
      if (pause_before > 0) begin
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic send_frame(input byte_queue_type f, input logic mark_last);
      foreach (f[i]) begin
         send_byte(f[i], mark_last && (i == f.size() - 1));
      end
      if (mark_last) begin
         frames_sent++;
      end
   endtask

   task automatic wait_idle();
      if (pause_before == 0) begin
         req_tvalid   <= 1'b0;
         pause_before = 1;
      end
      while (board.pending.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic apb_access(input logic write, input logic [CsrAddrWidth-1:0] addr,
                             input logic [CsrDataWidth-1:0] wdata,
                             output logic [CsrDataWidth-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_polynomial();
      logic [CsrDataWidth-1:0] rd;
      apb_access(1'b0, CSR_ADDR_POLY, '0, rd);
      if (rd !== {{(CsrDataWidth-8){1'b0}}, board.polynomial}) begin
         $display("%0t: crc_polynomial readback expected %h got %h", $time,
                  board.polynomial, rd);
         board.mismatches++;
      end
   endtask

   task automatic program_polynomial(input logic [CsrAddrWidth-1:0] addr,
                                     input logic [7:0] value);
      logic [CsrDataWidth-1:0] wdata;
      logic [CsrDataWidth-1:0] unused;
      wdata      = $urandom();
      wdata[7:0] = value;
      apb_access(1'b1, addr, wdata, unused);
      if (addr == CSR_ADDR_POLY) begin
         board.polynomial = value;
         poly_settings++;
      end
      check_polynomial();
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            board.check_verdict(rsp_tdata);
         end
         if (long_hold_request) begin
            stall_left        = LONG_HOLD;
            long_hold_request = 1'b0;
            long_holds++;
         end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      byte_queue_type f;
      logic [7:0]     head_crc;
      logic [7:0]     phase_poly [PHASES];
      int unsigned    target;
      phase_poly = '{8'h1D, 8'h00, 8'hFF, 8'h07, 8'h80, 8'h01, 8'h00};
      phase_poly[PHASES-1] = 8'($urandom());

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_polynomial();

      // good frame with extreme header bytes
      f = '{8'h00, 8'hFF, 8'h05, 8'hAA};
      f = {f, crc_of(f, board.polynomial, 8'h00)};
      send_frame(f, 1'b1);
      // too short: marked first byte, then three bytes
      send_frame('{8'hFF}, 1'b1);
      send_frame('{8'h00, 8'hFF, 8'h03}, 1'b1);
      // bad header outranks bad length
      send_frame('{8'h12, 8'h34, 8'h09, 8'h00, 8'hFF}, 1'b1);
      // bad length outranks bad crc
      send_frame('{8'hC3, 8'h3C, 8'h04, 8'h80, 8'h7F}, 1'b1);

      // unmapped write leaves the polynomial alone
      wait_idle();
      program_polynomial(UNMAPPED_ADDR, 8'h55);

      // polynomial change in the middle of a frame
      f = '{8'h5A, 8'hA5, 8'h06};
      head_crc = crc_of(f, board.polynomial, 8'h00);
      send_frame(f, 1'b0);
      wait_idle();
      program_polynomial(CSR_ADDR_POLY, 8'h07);
      f = '{8'h01, 8'hFE};
      f = {f, crc_of(f, board.polynomial, head_crc)};
      send_frame(f, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         program_polynomial(CSR_ADDR_POLY, phase_poly[p]);
         steady = (p == 2);
         if (p == 1) begin
            long_hold_request = 1'b1;
         end
         target = bytes_sent + RANDOM_BYTES / PHASES;
         while (bytes_sent < target) begin
            send_frame(random_frame(), 1'b1);
         end
      end
      steady = 1'b0;
      wait_idle();

      $display("Covered %0d bytes in %0d frames, %0d verdicts checked", bytes_sent,
               frames_sent, board.verdicts_checked);
      $display("Polynomial settings: %0d, long output hold-offs: %0d", poly_settings,
               long_holds);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("tb_crc8_frame_checker_unit: PASS");
      end else begin
         $display("tb_crc8_frame_checker_unit: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/crc8fc_pkg.sv
rtl/crc8fc_csr.sv
rtl/crc8fc_frame.sv
rtl/crc8_frame_checker_unit.sv
verif/tb_crc8_frame_checker_unit.sv
